>>> sv/rsamp_pkg.sv
// Shared types, constants and helper functions for the reservoir sampler.
// Used by every module of the block; depends on nothing.
package rsamp_pkg;

    localparam int RESERVOIR_DEPTH = 64;
    localparam int ID_WIDTH        = 32;
    localparam int SLOT_W          = $clog2(RESERVOIR_DEPTH);
    localparam int CNT_W           = 7;
    localparam int SEEN_W          = 32;
    localparam int DIV_W           = SEEN_W + 1;
    localparam int DIV_CNT_W       = $clog2(SEEN_W);
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 32;

    localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RNG_SEED     = 1'b1;

    // Item operations after classification.
    typedef enum logic {
        OP_OFFER   = 1'b0,
        OP_READOUT = 1'b1
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [ID_WIDTH-1:0] record_id;
    } cmd_t;

    typedef struct packed {
        logic                stored;
        logic [SLOT_W-1:0]   slot;
        logic [ID_WIDTH-1:0] sample_id;
        logic                last;
        logic                too_few;
    } res_t;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_t;

    // One xorshift32 step; the new state is also the draw.
    function automatic logic [SEEN_W-1:0] xorshift32(input logic [SEEN_W-1:0] s);
        logic [SEEN_W-1:0] x;
        x = s;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

    // Sample count as used: zero acts as one, large values clamp to the depth.
    function automatic logic [CNT_W-1:0] active_count(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] n;
        n = c;
        if (n == '0)
            n = CNT_W'(1);
        if (n > CNT_W'(RESERVOIR_DEPTH))
            n = CNT_W'(RESERVOIR_DEPTH);
        return n;
    endfunction

endpackage

>>> sv/reservoir_sampler_core.sv
// Reservoir sampler (Algorithm R) over a stream of 32-bit record handles.
// An offer item is stored directly while the reservoir fills; once it is full
// the generator steps, then a bit-serial remainder unit reduces the draw by
// the running count plus one, and that unit sets the offer rate. A readout
// item gives one result per slot, each read through S_RD and then S_EMIT,
// paced by the reservoir memory's registered read port, or a single
// too_few result when fewer records than sample_count have been seen. Slots
// that were never written read back undefined. Both sides are queues: up to
// two items wait at the input and two results at the output.
// Depends on rsamp_pkg, rsamp_front, rsamp_back and rsamp_outq.
module reservoir_sampler_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rsamp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rsamp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             push,
    output logic                             full,
    input  logic                             mode,
    input  logic [rsamp_pkg::ID_WIDTH-1:0]   record_id,
    output logic                             empty,
    input  logic                             pop,
    output logic                             stored,
    output logic [rsamp_pkg::SLOT_W-1:0]     slot,
    output logic [rsamp_pkg::ID_WIDTH-1:0]   sample_id,
    output logic                             last,
    output logic                             too_few
);
    import rsamp_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;
    res_t res_in;
    res_t res_out;
    logic res_push;
    logic res_full;

    always_comb
    begin
        cfg.we    = cfg_we;
        cfg.index = cfg_index;
        cfg.data  = cfg_data;
    end

    // Input side: accept and classify items.
    rsamp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .mode      (mode),
        .record_id (record_id),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    // Sampling engine.
    rsamp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    // Result side.
    rsamp_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .din   (res_in),
        .pop   (pop),
        .empty (empty),
        .dout  (res_out)
    );

    assign stored    = res_out.stored;
    assign slot      = res_out.slot;
    assign sample_id = res_out.sample_id;
    assign last      = res_out.last;
    assign too_few   = res_out.too_few;

endmodule

>>> sv/rsamp_front.sv
// Front end of the reservoir sampler: accepts input items, classifies them
// into offer or readout commands and buffers them in a two-entry queue.
// Depends on rsamp_pkg.
module rsamp_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          mode,
    input  logic [rsamp_pkg::ID_WIDTH-1:0] record_id,
    output logic                          cmd_valid,
    input  logic                          cmd_pop,
    output rsamp_pkg::cmd_t               cmd
);
    import rsamp_pkg::*;

    cmd_t       q_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;
    cmd_t       cmd_in;

    // Classify the item: the single mode bit selects the operation.
    always_comb
    begin
        cmd_in.op        = mode ? OP_READOUT : OP_OFFER;
        cmd_in.record_id = record_id;
    end

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;
    assign cmd       = q_mem[rd_ptr_reg];

    // Pointer and fill-count update.
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            q_mem[wr_ptr_reg] <= cmd_in;
    end

    // The back end never takes a command that is not there.
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command taken from an empty queue");

endmodule

>>> sv/rsamp_div.sv
// Bit-serial remainder unit: one restoring step per cycle over a 32-bit
// dividend and a 33-bit divisor. Depends on rsamp_pkg.
module rsamp_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rsamp_pkg::SEEN_W-1:0]  dividend,
    input  logic [rsamp_pkg::DIV_W-1:0]   divisor,
    output logic                          done,
    output logic [rsamp_pkg::DIV_W-1:0]   rem
);
    import rsamp_pkg::*;

    logic [SEEN_W-1:0]    dvd_reg, dvd_next;
    logic [DIV_W-1:0]     dsr_reg, dsr_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_W:0]       trial;

    assign trial = {rem_reg, dvd_reg[SEEN_W-1]};

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb
    begin
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = dvd_reg << 1;
            if (trial >= {1'b0, dsr_reg})
                rem_next = DIV_W'(trial - {1'b0, dsr_reg});
            else
                rem_next = DIV_W'(trial);
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(SEEN_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

    // A finished remainder is always below the divisor.
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < dsr_reg))
        else $error("remainder not below divisor");

endmodule

>>> sv/rsamp_back.sv
// Back end of the reservoir sampler: runs offer and readout commands, keeps
// the seen count, the generator, the configuration and the reservoir memory.
// Depends on rsamp_pkg and rsamp_div.
module rsamp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  rsamp_pkg::cfg_t   cfg,
    input  logic              cmd_valid,
    output logic              cmd_pop,
    input  rsamp_pkg::cmd_t   cmd,
    input  logic              res_full,
    output logic              res_push,
    output rsamp_pkg::res_t   res
);
    import rsamp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_PUT  = 5'b00100,
        S_RD   = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [SEEN_W-1:0]   seen_reg, seen_next;
    logic [SEEN_W-1:0]   prng_reg, prng_next;
    logic [CNT_W-1:0]    samp_cnt_reg, samp_cnt_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [ID_WIDTH-1:0] id_reg, id_next;
    res_t                res_reg, res_next;
    logic [ID_WIDTH-1:0] rdata_reg;
    logic [ID_WIDTH-1:0] mem [RESERVOIR_DEPTH];

    logic                mem_we;
    logic [SLOT_W-1:0]   mem_waddr;
    logic [ID_WIDTH-1:0] mem_wdata;
    logic [CNT_W-1:0]    n;
    logic                below_n;
    logic [SEEN_W-1:0]   draw;
    logic                div_start;
    logic                div_done;
    logic [DIV_W-1:0]    div_rem;
    logic                emit_last;
    res_t                emit_res;

    assign n       = active_count(samp_cnt_reg);
    assign below_n = (seen_reg < SEEN_W'(n));
    assign draw    = xorshift32(prng_reg);

    // Remainder of the draw by the running count plus one.
    rsamp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (draw),
        .divisor  ({1'b0, seen_reg} + DIV_W'(1)),
        .done     (div_done),
        .rem      (div_rem)
    );

    // Readout result straight from the registered memory data.
    assign emit_last = ((idx_reg + CNT_W'(1)) == n);
    always_comb
    begin
        emit_res.stored    = 1'b0;
        emit_res.slot      = idx_reg[SLOT_W-1:0];
        emit_res.sample_id = rdata_reg;
        emit_res.last      = emit_last;
        emit_res.too_few   = 1'b0;
    end

    assign res = (state_reg == S_EMIT) ? emit_res : res_reg;

    // Command sequencer.
    always_comb
    begin
        state_next    = state_reg;
        seen_next     = seen_reg;
        prng_next     = prng_reg;
        samp_cnt_next = samp_cnt_reg;
        idx_next      = idx_reg;
        id_next       = id_reg;
        res_next      = res_reg;
        mem_we        = 1'b0;
        mem_waddr     = seen_reg[SLOT_W-1:0];
        mem_wdata     = cmd.record_id;
        div_start     = 1'b0;
        cmd_pop       = 1'b0;
        res_push      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop           = 1'b1;
                    res_next.stored   = 1'b0;
                    res_next.slot     = '0;
                    res_next.sample_id = '0;
                    res_next.last     = 1'b1;
                    res_next.too_few  = 1'b0;
                    if (cmd.op == OP_OFFER)
                    begin
                        if (below_n)
                        begin
                            // Reservoir still filling: store in the next slot.
                            mem_we          = 1'b1;
                            res_next.stored = 1'b1;
                            res_next.slot   = seen_reg[SLOT_W-1:0];
                            seen_next       = seen_reg + SEEN_W'(1);
                            state_next      = S_PUT;
                        end
                        else
                        begin
                            prng_next  = draw;
                            div_start  = 1'b1;
                            id_next    = cmd.record_id;
                            state_next = S_DIV;
                        end
                    end
                    else if (below_n)
                    begin
                        res_next.too_few = 1'b1;
                        state_next       = S_PUT;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_RD;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    mem_waddr = div_rem[SLOT_W-1:0];
                    mem_wdata = id_reg;
                    if (div_rem < DIV_W'(n))
                    begin
                        // Draw landed inside the reservoir: replace that slot.
                        mem_we          = 1'b1;
                        res_next.stored = 1'b1;
                        res_next.slot   = div_rem[SLOT_W-1:0];
                    end
                    if (seen_reg != SEEN_MAX)
                        seen_next = seen_reg + SEEN_W'(1);
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RD:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!res_full)
                begin
                    res_push = 1'b1;
                    if (emit_last)
                        state_next = S_IDLE;
                    else
                    begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Register writes; a seed write also reloads the generator.
        if (cfg.we)
        begin
            case (cfg.index)
                REG_SAMPLE_COUNT:
                begin
                    samp_cnt_next = cfg.data[CNT_W-1:0];
                end
                REG_RNG_SEED:
                begin
                    prng_next = (cfg.data[SEEN_W-1:0] == '0) ? SEEN_W'(1)
                                                              : cfg.data[SEEN_W-1:0];
                end
                default:
                begin
                    samp_cnt_next = samp_cnt_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            seen_reg     <= '0;
            prng_reg     <= SEEN_W'(1);
            samp_cnt_reg <= CNT_W'(1);
            idx_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            seen_reg     <= seen_next;
            prng_reg     <= prng_next;
            samp_cnt_reg <= samp_cnt_next;
            idx_reg      <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        res_reg <= res_next;
    end

    // Reservoir memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[idx_reg[SLOT_W-1:0]];
    end

    // Results are only pushed where the output queue has room.
    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    // A stored offer always names a slot inside the active reservoir.
    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.stored) |-> (CNT_W'(res.slot) < n))
        else $error("stored slot outside the active reservoir");

    // Commands are only taken while the sequencer is idle.
    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (state_reg == S_IDLE))
        else $error("command taken while busy");

endmodule

>>> sv/rsamp_outq.sv
// Two-entry result queue between the back end and the result ports.
// Depends on rsamp_pkg.
module rsamp_outq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  rsamp_pkg::res_t din,
    input  logic            pop,
    output logic            empty,
    output rsamp_pkg::res_t dout
);
    import rsamp_pkg::*;

    res_t       q_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = q_mem[rd_ptr_reg];

    // Pointer and fill-count update.
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            q_mem[wr_ptr_reg] <= din;
    end

endmodule

>>> tb/reservoir_check.sv
`timescale 1ns / 100ps
// Checker for the reservoir sampler: watches the register port and both item channels,
// predicts every result from its own copy of the sampler state and compares in order.
// Depends on rsamp_pkg for the result layout, the operation codes and the register indexes.
module reservoir_check (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rsamp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rsamp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             push,
    input  logic                             full,
    input  logic                             mode,
    input  logic [rsamp_pkg::ID_WIDTH-1:0]   record_id,
    input  logic                             empty,
    input  logic                             pop,
    input  logic                             stored,
    input  logic [rsamp_pkg::SLOT_W-1:0]     slot,
    input  logic [rsamp_pkg::ID_WIDTH-1:0]   sample_id,
    input  logic                             last,
    input  logic                             too_few,
    output int                               mismatches,
    output int                               outstanding
);

    // Model of the sampler state.
    logic [31:0]    seen;
    logic [31:0]    bank [0:rsamp_pkg::RESERVOIR_DEPTH-1];
    logic [31:0]    rng;
    logic [6:0]     keep;

    // Results predicted but not yet popped, oldest first.
    rsamp_pkg::res_t awaited[$];

    int errors = 0;
    assign mismatches = errors;

    always @(posedge clk)
    begin : track
        logic [31:0]     n;
        logic [32:0]     rem;
        logic [5:0]      pos;
        logic            hit;
        rsamp_pkg::res_t want;
        rsamp_pkg::res_t got;

        if (!rst_n)
        begin
            seen = '0;
            rng = 32'd1;
            keep = 7'd1;
            awaited.delete();
            outstanding <= 0;
        end
        else
        begin
            // Register writes take effect at once; a zero seed is loaded as one.
            if (cfg_we)
            begin
                if (cfg_index == rsamp_pkg::REG_SAMPLE_COUNT)
                    keep = cfg_data[6:0];
                else if (cfg_index == rsamp_pkg::REG_RNG_SEED)
                    rng = (cfg_data == '0) ? 32'd1 : cfg_data;
            end

            // Number of slots in use: zero acts as one, large values clamp to the depth.
            n = (keep == '0) ? 32'd1 :
                (keep > 7'(rsamp_pkg::RESERVOIR_DEPTH)) ? 32'(rsamp_pkg::RESERVOIR_DEPTH) :
                32'(keep);

            // Accepted input item: work out the results it causes.
            if (push && !full)
            begin
                if (mode == rsamp_pkg::OP_OFFER)
                begin
                    hit = 1'b0;
                    pos = '0;
                    if (seen < n)
                    begin
                        hit = 1'b1;
                        pos = seen[5:0];
                    end
                    else
                    begin
                        // The generator only steps once the reservoir is full.
                        rng = rng ^ (rng << 13);
                        rng = rng ^ (rng >> 17);
                        rng = rng ^ (rng << 5);
                        rem = {1'b0, rng} % ({1'b0, seen} + 33'd1);
                        if (rem < {1'b0, n})
                        begin
                            hit = 1'b1;
                            pos = rem[5:0];
                        end
                    end
                    if (hit)
                        bank[pos] = record_id;
                    if (seen != '1)
                        seen = seen + 32'd1;
                    want.stored = hit;
                    want.slot = pos;
                    want.sample_id = '0;
                    want.last = 1'b1;
                    want.too_few = 1'b0;
                    awaited.push_back(want);
                end
                else if (seen < n)
                begin
                    // Readout before enough records were seen.
                    want.stored = 1'b0;
                    want.slot = '0;
                    want.sample_id = '0;
                    want.last = 1'b1;
                    want.too_few = 1'b1;
                    awaited.push_back(want);
                end
                else
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        want.stored = 1'b0;
                        want.slot = i[5:0];
                        want.sample_id = bank[i];
                        want.last = (i + 1 == n);
                        want.too_few = 1'b0;
                        awaited.push_back(want);
                    end
                end
            end

            // Accepted result: compare with the oldest prediction.
            if (pop && !empty)
            begin
                got.stored = stored;
                got.slot = slot;
                got.sample_id = sample_id;
                got.last = last;
                got.too_few = too_few;
                if (awaited.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: unexpected result stored=%0d slot=%0d id=%h last=%0d too_few=%0d",
                                 $realtime, got.stored, got.slot, got.sample_id, got.last,
                                 got.too_few);
                    errors++;
                end
                else
                begin
                    want = awaited.pop_front();
                    if (got.stored !== want.stored || got.slot !== want.slot ||
                        got.sample_id !== want.sample_id || got.last !== want.last ||
                        got.too_few !== want.too_few)
                    begin
                        if (errors < 10)
                        begin
                            $display("%0t: result differs, expected stored=%0d slot=%0d id=%h last=%0d too_few=%0d",
                                     $realtime, want.stored, want.slot, want.sample_id,
                                     want.last, want.too_few);
                            $display("%0t:                 actual   stored=%0d slot=%0d id=%h last=%0d too_few=%0d",
                                     $realtime, got.stored, got.slot, got.sample_id,
                                     got.last, got.too_few);
                        end
                        errors++;
                    end
                end
            end

            outstanding <= awaited.size();
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Top of the reservoir sampler testbench: clock, reset, register writes, item stimulus
// and result popping, with the verdict taken from reservoir_check.
// Depends on rsamp_pkg, reservoir_sampler_core and reservoir_check.
module testbench;

    logic                             clk;
    logic                             rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [rsamp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rsamp_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                             push = 1'b0;
    logic                             full;
    logic                             mode = 1'b0;
    logic [rsamp_pkg::ID_WIDTH-1:0]   record_id = '0;
    logic                             empty;
    logic                             pop = 1'b0;
    logic                             stored;
    logic [rsamp_pkg::SLOT_W-1:0]     slot;
    logic [rsamp_pkg::ID_WIDTH-1:0]   sample_id;
    logic                             last;
    logic                             too_few;
    int                               mismatches;
    int                               outstanding;

    // No idling on either side while calm is set.
    logic calm = 1'b0;
    logic hold_req = 1'b0;
    int   hold_left = 0;

    // Stimulus bookkeeping: records offered, slots written from zero up, sample count.
    int         offered = 0;
    int         filled = 0;
    logic [6:0] count_reg = 7'd1;

    reservoir_sampler_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .mode      (mode),
        .record_id (record_id),
        .empty     (empty),
        .pop       (pop),
        .stored    (stored),
        .slot      (slot),
        .sample_id (sample_id),
        .last      (last),
        .too_few   (too_few)
    );

    reservoir_check u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .mode        (mode),
        .record_id   (record_id),
        .empty       (empty),
        .pop         (pop),
        .stored      (stored),
        .slot        (slot),
        .sample_id   (sample_id),
        .last        (last),
        .too_few     (too_few),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Result side: random stalls, or a long hold-off when asked for one.
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (hold_left != 0)
        begin
            pop <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req)
        begin
            pop <= 1'b0;
            hold_left <= 400;
        end
        else
            pop <= calm || ($urandom_range(99) >= 29);
    end

    function automatic int kept(input logic [6:0] c);
        if (c == '0)
            return 1;
        if (c > 7'(rsamp_pkg::RESERVOIR_DEPTH))
            return rsamp_pkg::RESERVOIR_DEPTH;
        return int'(c);
    endfunction

    // Offer or read out one item. A readout that would reach a slot never written is
    // turned into an offer.
    task automatic issue(input logic m, input logic [31:0] id);
        logic op;
        int   n;
        n = kept(count_reg);
        op = m;
        if (op == rsamp_pkg::OP_READOUT && offered >= n && filled < n)
            op = rsamp_pkg::OP_OFFER;
        if (op == rsamp_pkg::OP_OFFER)
        begin
            if (offered < n && filled < offered + 1)
                filled = offered + 1;
            offered++;
        end
        while (!calm && $urandom_range(99) < 29)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        mode <= op;
        record_id <= id;
        do
            @(posedge clk);
        while (full);
    endtask

    // Register write, only once every predicted result has been popped.
    task automatic write_reg(input logic [rsamp_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == rsamp_pkg::REG_SAMPLE_COUNT)
            count_reg = val[6:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [31:0] w;
        logic [6:0]  nval;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: readout before any record, then one record and its readout.
        issue(rsamp_pkg::OP_READOUT, $urandom());
        issue(rsamp_pkg::OP_OFFER, 32'hFFFF_FFFF);
        issue(rsamp_pkg::OP_READOUT, $urandom());

        // Full depth with an all-ones seed; upper data bits of the count are don't-care.
        w = $urandom();
        w[6:0] = 7'd64;
        write_reg(rsamp_pkg::REG_SAMPLE_COUNT, w);
        write_reg(rsamp_pkg::REG_RNG_SEED, 32'hFFFF_FFFF);
        issue(rsamp_pkg::OP_READOUT, $urandom());
        issue(rsamp_pkg::OP_OFFER, 32'h0000_0000);
        issue(rsamp_pkg::OP_OFFER, 32'h8000_0000);
        issue(rsamp_pkg::OP_OFFER, 32'h0000_0001);
        issue(rsamp_pkg::OP_OFFER, 32'h5555_5555);
        issue(rsamp_pkg::OP_OFFER, 32'hAAAA_AAAA);

        // Fill every slot so that any later sample count can be read out.
        while (offered < rsamp_pkg::RESERVOIR_DEPTH)
        begin
            if ($urandom_range(99) < 10)
                issue(rsamp_pkg::OP_READOUT, $urandom());
            else
                issue(rsamp_pkg::OP_OFFER, $urandom());
        end
        issue(rsamp_pkg::OP_READOUT, $urandom());

        // Zero count acts as one, zero seed loads as one.
        w = $urandom();
        w[6:0] = 7'd0;
        write_reg(rsamp_pkg::REG_SAMPLE_COUNT, w);
        write_reg(rsamp_pkg::REG_RNG_SEED, 32'h0000_0000);
        issue(rsamp_pkg::OP_OFFER, $urandom());
        issue(rsamp_pkg::OP_OFFER, $urandom());
        issue(rsamp_pkg::OP_READOUT, $urandom());

        // A count above the depth clamps to the depth.
        w = $urandom();
        w[6:0] = 7'd127;
        write_reg(rsamp_pkg::REG_SAMPLE_COUNT, w);
        issue(rsamp_pkg::OP_READOUT, $urandom());
        issue(rsamp_pkg::OP_OFFER, $urandom());

        // Random phases, each with its own sample count and seed.
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: nval = 7'd1;
                1: nval = 7'd64;
                2: nval = 7'd0;
                3: nval = 7'd127;
                default: nval = 7'($urandom_range(1, rsamp_pkg::RESERVOIR_DEPTH));
            endcase
            w = $urandom();
            w[6:0] = nval;
            write_reg(rsamp_pkg::REG_SAMPLE_COUNT, w);
            case ($urandom_range(0, 5))
                0: w = 32'h0000_0000;
                1: w = 32'hFFFF_FFFF;
                default: w = $urandom();
            endcase
            write_reg(rsamp_pkg::REG_RNG_SEED, w);

            calm <= (p == 4);
            if (p == 1)
            begin
                // Hold off the result side while items keep coming.
                hold_req <= 1'b1;
                @(posedge clk);
                hold_req <= 1'b0;
            end

            for (int k = 0; k < 50; k++)
            begin
                if (p == 5 && k == 25)
                begin
                    // Pause the item side until every result has been popped.
                    push <= 1'b0;
                    @(posedge clk);
                    while (outstanding != 0)
                        @(posedge clk);
                end
                if ($urandom_range(99) < 15)
                    issue(rsamp_pkg::OP_READOUT, $urandom());
                else
                    issue(rsamp_pkg::OP_OFFER, $urandom());
            end
        end

        // Drain and give the verdict.
        push <= 1'b0;
        calm <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog for a hung run.
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
